/* design/shc_pkg.sv */
`default_nettype none
package shc_pkg;

    localparam int GRAINS_W = 5;
    localparam int RC_CFG_W = 7;
    localparam int POS_W    = 16;
    localparam int CNT_W    = 16;
    localparam int UNI_W    = 16;
    localparam int TOT_W    = 32;
    localparam int OUT_RC_W = 6;
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int PROD_W   = POS_W + GRAINS_W;
    localparam int IDX_W    = PROD_W - 8;
    localparam int TGT_W    = TOT_W + UNI_W;

    localparam logic [GRAINS_W-1:0] GRAINS_RST = GRAINS_W'(1);
    localparam logic [RC_CFG_W-1:0] ROWS_RST   = RC_CFG_W'(64);
    localparam logic [RC_CFG_W-1:0] COLS_RST   = RC_CFG_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_OOB   = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_GRAINS = 2'd0,
        REG_ROWS   = 2'd1,
        REG_COLS   = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_ADD_IDX,
        S_ADD_RD,
        S_ADD_WR,
        S_SMP_PREP,
        S_SMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [GRAINS_W-1:0] grains;
        logic [RC_CFG_W-1:0] rows_used;
        logic [RC_CFG_W-1:0] cols_used;
    } cfg_t;

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* design/shc_ram.sv */
`default_nettype none
module shc_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 4096,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          addr,
    input  wire logic [WIDTH-1:0]       wdata,
    output logic      [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

/* design/shc_cfg.sv */
`default_nettype none
module shc_cfg
    import shc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);
    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (paddr[3:2])
            REG_GRAINS: begin
                prdata = APB_DW'(cfg_reg.grains);
                if (wr_en) cfg_next.grains = pwdata[GRAINS_W-1:0];
            end
            REG_ROWS: begin
                prdata = APB_DW'(cfg_reg.rows_used);
                if (wr_en) cfg_next.rows_used = pwdata[RC_CFG_W-1:0];
            end
            REG_COLS: begin
                prdata = APB_DW'(cfg_reg.cols_used);
                if (wr_en) cfg_next.cols_used = pwdata[RC_CFG_W-1:0];
            end
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grains    <= GRAINS_RST;
            cfg_reg.rows_used <= ROWS_RST;
            cfg_reg.cols_used <= COLS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

/* design/shc_seq.sv */
`default_nettype none
module shc_seq
    import shc_pkg::*;
#(
    parameter  int MAX_ROWS = 64,
    parameter  int MAX_COLS = 64,
    localparam int DEPTH    = MAX_ROWS * MAX_COLS,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [OP_W-1:0]      s_operation,
    input  wire logic [POS_W-1:0]     s_pos_x,
    input  wire logic [POS_W-1:0]     s_pos_y,
    input  wire logic [CNT_W-1:0]     s_count,
    input  wire logic [UNI_W-1:0]     s_uniform,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [ST_W-1:0]      m_status,
    output logic      [OUT_RC_W-1:0]  m_bin_row,
    output logic      [OUT_RC_W-1:0]  m_bin_col,
    output logic      [TOT_W-1:0]     m_total_events,
    output logic                      mem_we,
    output logic      [AW-1:0]        mem_addr,
    output logic      [TOT_W-1:0]     mem_wdata,
    input  wire logic [TOT_W-1:0]     mem_rdata
);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RNW   = ($clog2(MAX_ROWS + 1) > RC_CFG_W) ? $clog2(MAX_ROWS + 1) : RC_CFG_W;
    localparam int CNW   = ($clog2(MAX_COLS + 1) > RC_CFG_W) ? $clog2(MAX_COLS + 1) : RC_CFG_W;

    state_t state_reg, state_next;

    logic [POS_W-1:0]    px_reg, px_next;
    logic [POS_W-1:0]    py_reg, py_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [UNI_W-1:0]    uni_reg, uni_next;
    logic [IDX_W-1:0]    ridx_reg, ridx_next;
    logic [IDX_W-1:0]    cidx_reg, cidx_next;
    logic [AW-1:0]       sweep_reg, sweep_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic [TGT_W-1:0]    target_reg, target_next;
    logic [TOT_W-1:0]    cum_reg, cum_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [AW-1:0]       base_reg, base_next;
    logic                issue_done_reg, issue_done_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                rd_last_reg, rd_last_next;
    logic [RW-1:0]       rd_row_reg, rd_row_next;
    logic [CW-1:0]       rd_col_reg, rd_col_next;
    status_t             res_status_reg, res_status_next;
    logic [OUT_RC_W-1:0] res_row_reg, res_row_next;
    logic [OUT_RC_W-1:0] res_col_reg, res_col_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [OUT_RC_W-1:0] m_row_reg, m_row_next;
    logic [OUT_RC_W-1:0] m_col_reg, m_col_next;
    logic [TOT_W-1:0]    m_total_reg, m_total_next;

    logic [RNW-1:0]      eff_rows;
    logic [CNW-1:0]      eff_cols;
    logic [TOT_W-1:0]    cum_sum;
    logic                hit;
    logic                row_end;
    logic                col_end;
    logic                oob;

    assign eff_rows = (RNW'(cfg.rows_used) > RNW'(MAX_ROWS)) ? RNW'(MAX_ROWS)
                                                             : RNW'(cfg.rows_used);
    assign eff_cols = (CNW'(cfg.cols_used) > CNW'(MAX_COLS)) ? CNW'(MAX_COLS)
                                                             : CNW'(cfg.cols_used);

    assign cum_sum = sat_add(cum_reg, mem_rdata);
    assign hit     = target_reg <= {cum_sum, {UNI_W{1'b0}}};
    assign row_end = RNW'(row_reg) == eff_rows - RNW'(1);
    assign col_end = CNW'(col_reg) == eff_cols - CNW'(1);
    assign oob     = (ridx_reg >= IDX_W'(eff_rows)) || (cidx_reg >= IDX_W'(eff_cols));

    assign s_ready        = state_reg == S_IDLE;
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_bin_row      = m_row_reg;
    assign m_bin_col      = m_col_reg;
    assign m_total_events = m_total_reg;

    always_comb begin
        state_next      = state_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        cnt_next        = cnt_reg;
        uni_next        = uni_reg;
        ridx_next       = ridx_reg;
        cidx_next       = cidx_reg;
        sweep_next      = sweep_reg;
        total_next      = total_reg;
        target_next     = target_reg;
        cum_next        = cum_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = 1'b0;
        rd_last_next    = rd_last_reg;
        rd_row_next     = rd_row_reg;
        rd_col_next     = rd_col_reg;
        res_status_next = res_status_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_row_next      = m_row_reg;
        m_col_next      = m_col_reg;
        m_total_next    = m_total_reg;
        mem_we          = 1'b0;
        mem_addr        = sweep_reg;
        mem_wdata       = '0;

        unique case (state_reg)
            S_INIT, S_CLEAR: begin
                // zero one bin per cycle
                mem_we   = 1'b1;
                mem_addr = sweep_reg;
                if (sweep_reg == AW'(DEPTH - 1)) begin
                    sweep_next = '0;
                    if (state_reg == S_CLEAR) begin
                        total_next      = '0;
                        res_status_next = ST_OK;
                        res_row_next    = '0;
                        res_col_next    = '0;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    px_next  = s_pos_x;
                    py_next  = s_pos_y;
                    cnt_next = s_count;
                    uni_next = s_uniform;
                    unique case (op_t'(s_operation))
                        OP_CLEAR:  state_next = S_CLEAR;
                        OP_ADD:    state_next = S_ADD_IDX;
                        OP_SAMPLE: state_next = S_SMP_PREP;
                        default: begin
                            res_status_next = ST_OK;
                            res_row_next    = '0;
                            res_col_next    = '0;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_ADD_IDX: begin
                ridx_next  = IDX_W'((PROD_W'(px_reg) * PROD_W'(cfg.grains)) >> 8);
                cidx_next  = IDX_W'((PROD_W'(py_reg) * PROD_W'(cfg.grains)) >> 8);
                state_next = S_ADD_RD;
            end
            S_ADD_RD: begin
                mem_addr = AW'(ridx_reg[RW-1:0]) * AW'(MAX_COLS) + AW'(cidx_reg[CW-1:0]);
                if (oob) begin
                    res_status_next = ST_OOB;
                    res_row_next    = '0;
                    res_col_next    = '0;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                mem_we          = 1'b1;
                mem_addr        = AW'(ridx_reg[RW-1:0]) * AW'(MAX_COLS)
                                + AW'(cidx_reg[CW-1:0]);
                mem_wdata       = sat_add(mem_rdata, TOT_W'(cnt_reg));
                total_next      = sat_add(total_reg, TOT_W'(cnt_reg));
                res_status_next = ST_OK;
                res_row_next    = ridx_reg[OUT_RC_W-1:0];
                res_col_next    = cidx_reg[OUT_RC_W-1:0];
                state_next      = S_DONE;
            end
            S_SMP_PREP: begin
                target_next     = TGT_W'(uni_reg) * TGT_W'(total_reg);
                cum_next        = '0;
                row_next        = '0;
                col_next        = '0;
                base_next       = '0;
                issue_done_next = 1'b0;
                if (total_reg == '0 || eff_rows == '0 || eff_cols == '0) begin
                    res_status_next = ST_EMPTY;
                    res_row_next    = '0;
                    res_col_next    = '0;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_SMP;
                end
            end
            S_SMP: begin
                // issue one read per cycle, check the bin read last cycle
                mem_addr = base_reg + AW'(col_reg);
                if (!issue_done_reg) begin
                    rd_vld_next  = 1'b1;
                    rd_row_next  = row_reg;
                    rd_col_next  = col_reg;
                    rd_last_next = row_end && col_end;
                    if (row_end && col_end) begin
                        issue_done_next = 1'b1;
                    end else if (col_end) begin
                        col_next  = '0;
                        row_next  = row_reg + RW'(1);
                        base_next = base_reg + AW'(MAX_COLS);
                    end else begin
                        col_next = col_reg + CW'(1);
                    end
                end
                if (rd_vld_reg) begin
                    cum_next = cum_sum;
                    if (hit) begin
                        res_status_next = ST_OK;
                        res_row_next    = OUT_RC_W'(rd_row_reg);
                        res_col_next    = OUT_RC_W'(rd_col_reg);
                        state_next      = S_DONE;
                    end else if (rd_last_reg) begin
                        res_status_next = ST_EMPTY;
                        res_row_next    = '0;
                        res_col_next    = '0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_row_next    = res_row_reg;
                    m_col_next    = res_col_reg;
                    m_total_next  = total_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            sweep_reg      <= '0;
            total_reg      <= '0;
            issue_done_reg <= 1'b1;
            rd_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            total_reg      <= total_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg         <= px_next;
        py_reg         <= py_next;
        cnt_reg        <= cnt_next;
        uni_reg        <= uni_next;
        ridx_reg       <= ridx_next;
        cidx_reg       <= cidx_next;
        target_reg     <= target_next;
        cum_reg        <= cum_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        base_reg       <= base_next;
        rd_last_reg    <= rd_last_next;
        rd_row_reg     <= rd_row_next;
        rd_col_reg     <= rd_col_next;
        res_status_reg <= res_status_next;
        res_row_reg    <= res_row_next;
        res_col_reg    <= res_col_next;
        m_status_reg   <= m_status_next;
        m_row_reg      <= m_row_next;
        m_col_reg      <= m_col_next;
        m_total_reg    <= m_total_next;
    end

    // total only drops through a clear sweep
    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CLEAR && state_reg != S_INIT) |=> total_reg >= $past(total_reg))
        else $error("running total decreased outside a clear");

    a_no_write_in_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SMP || state_reg == S_SMP_PREP || state_reg == S_ADD_RD) |-> !mem_we)
        else $error("bin memory written during a read-only phase");

    a_flag_clears_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_OOB || m_status_reg == ST_EMPTY))
            |-> (m_row_reg == '0 && m_col_reg == '0))
        else $error("flagged result carries a nonzero bin");

    a_clear_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR && state_next == S_DONE) |=> total_reg == '0)
        else $error("total not zero after clear sweep");

    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INIT) |-> !s_ready)
        else $error("input taken during clearing pass");

endmodule
`default_nettype wire

/* design/site_histogram_cdf_sampler_top.sv */
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    operation, pos_x, pos_y, count, uniform
// m_        out        m_valid/m_ready    status, bin_row, bin_col, total_events
// APB       in         psel/penable/pwrite  grains @0x0, rows_used @0x4, cols_used @0x8
//
// After reset a clearing pass zeroes the bin memory before s_ready.
// Clear zeroes all bins; add reads a bin and writes back its sum, but not when out of bounds.
// Unused codes only return a result. Sample reads one bin per cycle from the single-port memory.
// The result register holds until m_ready; the next item is taken while it waits.
module site_histogram_cdf_sampler_top
    import shc_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic      [APB_DW-1:0]    prdata,
    output logic                      pready,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [OP_W-1:0]      s_operation,
    input  wire logic [POS_W-1:0]     s_pos_x,
    input  wire logic [POS_W-1:0]     s_pos_y,
    input  wire logic [CNT_W-1:0]     s_count,
    input  wire logic [UNI_W-1:0]     s_uniform,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [ST_W-1:0]      m_status,
    output logic      [OUT_RC_W-1:0]  m_bin_row,
    output logic      [OUT_RC_W-1:0]  m_bin_col,
    output logic      [TOT_W-1:0]     m_total_events
);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t             cfg;
    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [TOT_W-1:0] mem_wdata;
    logic [TOT_W-1:0] mem_rdata;

    shc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shc_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_count        (s_count),
        .s_uniform      (s_uniform),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_bin_row      (m_bin_row),
        .m_bin_col      (m_bin_col),
        .m_total_events (m_total_events),
        .mem_we         (mem_we),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata),
        .mem_rdata      (mem_rdata)
    );

    shc_ram #(
        .WIDTH (TOT_W),
        .DEPTH (DEPTH)
    ) u_bins (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire
